### hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned MaxSegments   = 16;
  localparam int unsigned AddrBits      = 32;
  localparam int unsigned OwnerBits     = 8;
  localparam logic [31:0] TotalSizeRst  = 32'd65536;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNoFit   = 3'd1,
    StFull    = 3'd2,
    StNoOwner = 3'd3,
    StZero    = 3'd4
  } status_e;

  typedef enum logic {
    FuncAlloc = 1'b0,
    FuncFree  = 1'b1
  } func_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  owner_id;
    logic [31:0] request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
  } rsp_t;

  typedef enum logic [3:0] {
    SIdle,
    SScanRd,
    SScanChk,
    SFitDecide,
    SShiftRd,
    SShiftWr,
    SSplit,
    SFreeNextRd,
    SFreeNextChk,
    SRemRd,
    SRemWr,
    SFreePrevRd,
    SFreePrevChk,
    SMergePrev,
    SResp
  } state_e;

endpackage

### hw/rtl/ffsa_seg_ram.sv
// ----------------------------------------------------------------------------
// ffsa_seg_ram
// Segment table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffsa_seg_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over an address-ordered segment table.
//
// Requests arrive on req (valid/ready) as a req_t: func, owner_id and
// request_size. Each request yields one response transfer on rsp with a
// status and, for a successful allocate, the block address.
// One request is in work at a time. The table is scanned one segment
// at a time, and an insert or a merge shifts the entries behind the
// segment one at a time, each read and then written back, as the
// segment store has a single read port; a zero-size allocate skips
// the scan. req_ready_o is low while a request is in work or its
// response waits; a stalled receiver holds the response in its output
// register and no further request is taken.
// After reset, and after a write of total_size, the table holds one free
// segment [0, total_size); this takes effect at once, no clearing pass.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
  parameter int unsigned MaxSeg = ffsa_pkg::MaxSegments
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [31:0]           cfg_wdata_i,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ffsa_pkg::req_t        req_i,
  output logic                  rsp_valid_o,
  input  logic                  rsp_ready_i,
  output ffsa_pkg::rsp_t        rsp_o
);

  import ffsa_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxSeg);
  localparam int unsigned CntW = $clog2(MaxSeg + 1);
  // entry word: free, owner, length, start
  localparam int unsigned EntW = 1 + OwnerBits + 2 * AddrBits;

  typedef struct packed {
    logic                 free;
    logic [OwnerBits-1:0] owner;
    logic [AddrBits-1:0]  len;
    logic [AddrBits-1:0]  start;
  } ent_t;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  req_t            req_q, req_d;
  ent_t            cur_q, cur_d;
  ent_t            aux_q, aux_d;
  rsp_t            rsp_q, rsp_d;
  logic            rsp_valid_q, rsp_valid_d;
  logic [31:0]     total_q;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  ent_t            wdata, rdata_raw, rdata;

  ffsa_seg_ram #(.Depth(MaxSeg), .Width(EntW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );

  // entry 0 reads as the initial free segment until first written
  logic ovr_q, rd0_q;
  always_comb begin
    rdata = rdata_raw;
    if (ovr_q && rd0_q) begin
      rdata.free  = 1'b1;
      rdata.owner = '0;
      rdata.len   = total_q[AddrBits-1:0];
      rdata.start = '0;
    end
  end

  logic [OwnerBits-1:0] own;
  logic [AddrBits-1:0]  rsz;
  assign own = req_q.owner_id[OwnerBits-1:0];
  assign rsz = req_q.request_size[AddrBits-1:0];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    req_d       = req_q;
    cur_d       = cur_q;
    aux_d       = aux_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    req_ready_o = 1'b0;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        req_ready_o = !rsp_valid_q;
        if (req_valid_i && !rsp_valid_q) begin
          req_d      = req_i;
          i_d        = '0;
          aux_d.free = 1'b0;
          rsp_d      = '{status: StOk, block_address: '0};
          if (req_i.func == FuncAlloc && req_i.request_size[AddrBits-1:0] == '0) begin
            rsp_d.status = StZero;
            state_d      = SResp;
          end else begin
            state_d = SScanRd;
          end
        end
      end
      SScanRd: begin
        if (i_q >= cnt_q) begin
          rsp_d.status = (req_q.func == FuncAlloc) ? StNoFit : StNoOwner;
          state_d      = SResp;
        end else begin
          raddr   = i_q[IdxW-1:0];
          state_d = SScanChk;
        end
      end
      SScanChk: begin
        cur_d = rdata;
        if (req_q.func == FuncAlloc) begin
          if (rdata.free && rdata.len >= rsz) begin
            state_d = SFitDecide;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = SScanRd;
          end
        end else begin
          if (!rdata.free && rdata.owner == own) begin
            cur_d.free  = 1'b1;
            cur_d.owner = '0;
            state_d     = SFreeNextRd;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = SScanRd;
          end
        end
      end
      SFitDecide: begin
        if (cur_q.len == rsz) begin
          we          = 1'b1;
          waddr       = i_q[IdxW-1:0];
          wdata       = cur_q;
          wdata.free  = 1'b0;
          wdata.owner = own;
          rsp_d.block_address = 32'(cur_q.start);
          state_d     = SResp;
        end else if (cnt_q >= CntW'(MaxSeg)) begin
          rsp_d.status = StFull;
          state_d      = SResp;
        end else begin
          j_d     = cnt_q;
          state_d = SShiftRd;
        end
      end
      SShiftRd: begin
        if (j_q == i_q + 1'b1) begin
          state_d = SSplit;
        end else begin
          raddr   = IdxW'(j_q - 1'b1);
          state_d = SShiftWr;
        end
      end
      SShiftWr: begin
        we      = 1'b1;
        waddr   = j_q[IdxW-1:0];
        wdata   = rdata;
        j_d     = j_q - 1'b1;
        state_d = SShiftRd;
      end
      SSplit: begin
        // write remainder at i+1 now, allocated block at i next
        we          = 1'b1;
        waddr       = IdxW'(i_q + 1'b1);
        wdata.free  = 1'b1;
        wdata.owner = cur_q.owner;
        wdata.start = cur_q.start + rsz;
        wdata.len   = cur_q.len - rsz;
        cnt_d       = cnt_q + 1'b1;
        aux_d       = cur_q;
        aux_d.free  = 1'b0;
        aux_d.owner = own;
        aux_d.len   = rsz;
        cur_d       = aux_d;
        rsp_d.block_address = 32'(cur_q.start);
        state_d     = SMergePrev;
        j_d         = i_q;
      end
      SFreeNextRd: begin
        if (i_q + 1'b1 < cnt_q) begin
          raddr   = IdxW'(i_q + 1'b1);
          state_d = SFreeNextChk;
        end else begin
          state_d = SFreePrevRd;
        end
      end
      SFreeNextChk: begin
        if (rdata.free) begin
          cur_d.len = cur_q.len + rdata.len;
          j_d       = i_q + 1'b1;
          state_d   = SRemRd;
        end else begin
          state_d = SFreePrevRd;
        end
      end
      SRemRd: begin
        if (j_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          if (aux_q.free) begin
            state_d = SResp;
          end else begin
            state_d = SFreePrevRd;
          end
        end else begin
          raddr   = IdxW'(j_q + 1'b1);
          state_d = SRemWr;
        end
      end
      SRemWr: begin
        we      = 1'b1;
        waddr   = j_q[IdxW-1:0];
        wdata   = rdata;
        j_d     = j_q + 1'b1;
        state_d = SRemRd;
      end
      SFreePrevRd: begin
        aux_d.free = 1'b0;
        if (i_q != '0) begin
          raddr   = IdxW'(i_q - 1'b1);
          state_d = SFreePrevChk;
        end else begin
          j_d     = i_q;
          state_d = SMergePrev;
        end
      end
      SFreePrevChk: begin
        if (rdata.free) begin
          we        = 1'b1;
          waddr     = IdxW'(i_q - 1'b1);
          wdata     = rdata;
          wdata.len = rdata.len + cur_q.len;
          j_d       = i_q;
          aux_d.free = 1'b1;
          state_d   = SRemRd;
        end else begin
          j_d     = i_q;
          state_d = SMergePrev;
        end
      end
      SMergePrev: begin
        we      = 1'b1;
        waddr   = j_q[IdxW-1:0];
        wdata   = cur_q;
        state_d = SResp;
      end
      SResp: begin
        rsp_valid_d = 1'b1;
        state_d     = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= CntW'(1);
      rsp_valid_q <= 1'b0;
      total_q     <= TotalSizeRst;
      ovr_q       <= 1'b1;
      rd0_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      rd0_q       <= (raddr == '0);
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
        cnt_q   <= CntW'(1);
        ovr_q   <= 1'b1;
      end else begin
        cnt_q <= cnt_d;
        if (we && waddr == '0) begin
          ovr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    req_q <= req_d;
    cur_q <= cur_d;
    aux_q <= aux_d;
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### hw/rtl/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffsa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input ffsa_pkg::rsp_t rsp_o
);

  import ffsa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped or changed while stalled");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request taken while response pending");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.status <= StZero)
    else $error("bad status");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StOk |-> rsp_o.block_address == '0)
    else $error("address on failed request");

  a_one_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !rsp_valid_o)
    else $error("response too early");

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_valid_i),
  .req_ready_o (req_ready_o),
  .rsp_valid_o (rsp_valid_o),
  .rsp_ready_i (rsp_ready_i),
  .rsp_o       (rsp_o)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit segment allocator: a predictor keeps
// its own segment table, random alloc/free traffic runs under several
// idling phases and total_size settings, responses are checked in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  class alloc_scoreboard;
    logic [31:0] total;
    logic [31:0] seg_base [MaxSegments];
    logic [31:0] seg_len [MaxSegments];
    logic [7:0]  seg_own [MaxSegments];
    bit          seg_free [MaxSegments];
    int          seg_num;
    rsp_t        pending [$];
    int          mismatches;
    int          checked;

    function void clear_table(logic [31:0] sz);
      total = sz;
      for (int k = 0; k < MaxSegments; k++) begin
        seg_base[k] = 0; seg_len[k] = 0; seg_own[k] = 0; seg_free[k] = 0;
      end
      seg_len[0] = sz;
      seg_free[0] = 1;
      seg_num = 1;
    endfunction

    function void drop_entry(int k);
      for (int j = k; j + 1 < seg_num; j++) begin
        seg_base[j] = seg_base[j+1]; seg_len[j] = seg_len[j+1];
        seg_own[j] = seg_own[j+1]; seg_free[j] = seg_free[j+1];
      end
      seg_num--;
      seg_base[seg_num] = 0; seg_len[seg_num] = 0;
      seg_own[seg_num] = 0; seg_free[seg_num] = 0;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int i;
      e = '0;
      if (r.func == FuncAlloc) begin
        if (r.request_size == 0) e.status = StZero;
        else begin
          for (i = 0; i < seg_num; i++)
            if (seg_free[i] && seg_len[i] >= r.request_size) break;
          if (i >= seg_num) e.status = StNoFit;
          else if (seg_len[i] == r.request_size) begin
            seg_free[i] = 0; seg_own[i] = r.owner_id;
            e.status = StOk; e.block_address = seg_base[i];
          end else if (seg_num >= MaxSegments) e.status = StFull;
          else begin
            for (int j = seg_num; j > i; j--) begin
              seg_base[j] = seg_base[j-1]; seg_len[j] = seg_len[j-1];
              seg_own[j] = seg_own[j-1]; seg_free[j] = seg_free[j-1];
            end
            seg_num++;
            seg_len[i] = r.request_size; seg_own[i] = r.owner_id; seg_free[i] = 0;
            seg_base[i+1] = seg_base[i] + r.request_size;
            seg_len[i+1] = seg_len[i+1] - r.request_size;
            e.status = StOk; e.block_address = seg_base[i];
          end
        end
      end else begin
        for (i = 0; i < seg_num; i++)
          if (!seg_free[i] && seg_own[i] == r.owner_id) break;
        if (i >= seg_num) e.status = StNoOwner;
        else begin
          seg_free[i] = 1; seg_own[i] = 0;
          if (i + 1 < seg_num && seg_free[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1];
            drop_entry(i + 1);
          end
          if (i > 0 && seg_free[i-1]) begin
            seg_len[i-1] = seg_len[i-1] + seg_len[i];
            drop_entry(i);
          end
          e.status = StOk;
        end
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.block_address !== e.block_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                   e.status, got.status, e.block_address, got.block_address);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        req_valid_i, req_ready_o, rsp_valid_o, rsp_ready_i;
  req_t        req_i;
  rsp_t        rsp_o;

  alloc_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int quiet_cycles, sent, cfg_count;
  bit timed_out;
  localparam int QuietLimit = 20000;

  first_fit_segment_allocator DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .req_valid_i, .req_ready_o, .req_i,
    .rsp_valid_o, .rsp_ready_i, .rsp_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) sb.check_response(rsp_o);
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      rsp_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic write_total(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.clear_table(v);
    cfg_count++;
  endtask

  task automatic send_request(bit f, logic [7:0] own, logic [31:0] sz);
    req_t r;
    r.func = f; r.owner_id = own; r.request_size = sz;
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    req_valid_i <= 1; req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
    sb.note_request(r);
    sent++;
  endtask

  task automatic drain();
    req_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_size(logic [31:0] tot);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 0;
      2: return tot;
      default: return $urandom_range(1, (tot > 0 && tot < 4096) ? tot : 4096);
    endcase
  endfunction

  task automatic random_phase(int n, logic [31:0] tot);
    logic [7:0] own;
    for (int k = 0; k < n; k++) begin
      own = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(7));
      if ($urandom_range(99) < 55) send_request(FuncAlloc, own, pick_size(tot));
      else send_request(FuncFree, own, $urandom());
    end
  endtask

  initial begin
    sb = new();
    sb.clear_table(TotalSizeRst);
    cfg_we_i = 0; cfg_wdata_i = 0; req_valid_i = 0; req_i = '0; rsp_ready_i = 1;
    send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_request(FuncAlloc, 8'h00, 32'd0);
    send_request(FuncFree, 8'hFF, 32'hFFFF_FFFF);
    send_request(FuncAlloc, 8'hFF, 32'hFFFF_FFFF);
    send_request(FuncAlloc, 8'h01, 32'd100);
    send_request(FuncAlloc, 8'h02, 32'd200);
    send_request(FuncAlloc, 8'h03, 32'd300);
    send_request(FuncFree, 8'h02, 32'd0);
    send_request(FuncAlloc, 8'h04, 32'd200);
    send_request(FuncFree, 8'h01, 32'd0);
    send_request(FuncFree, 8'h04, 32'd0);
    send_request(FuncFree, 8'h03, 32'd0);
    for (int k = 0; k < 17; k++) send_request(FuncAlloc, 8'(k), 32'd16);
    send_request(FuncAlloc, 8'hAA, 32'd70000);
    drain();
    write_total(32'd0);
    send_request(FuncAlloc, 8'h00, 32'd1);
    send_request(FuncAlloc, 8'h00, 32'd0);
    drain();
    write_total(32'hFFFF_FFFF);
    send_request(FuncAlloc, 8'h55, 32'hFFFF_FFFF);
    send_request(FuncFree, 8'h55, 32'd0);
    send_request(FuncAlloc, 8'h55, 32'h8000_0000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      logic [31:0] tot;
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 86; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 86; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      case (ph)
        0: tot = 32'd1;
        3: tot = 32'hFFFF_FFFF;
        5: tot = $urandom();
        default: tot = $urandom_range(64, 20000);
      endcase
      write_total(tot);
      random_phase(100, tot);
      drain();
    end

    $display("covered %0d requests over %0d total_size settings, %0d responses",
             sent, cfg_count, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
